@@ hw/rtl/oriented_circle_tangent_points_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the tangent point block
// Shared property forms: same-cycle implication and next-cycle implication.
// ---------------------------------------------------------------------------
`ifndef ORIENTED_CIRCLE_TANGENT_POINTS_ASSERT_SVH
`define ORIENTED_CIRCLE_TANGENT_POINTS_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define OTP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante holds -> cons holds in the next cycle
`define OTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/otp_pkg.sv @@
// ---------------------------------------------------------------------------
// otp_pkg
// Types and constants of the oriented circle tangent point pipeline.
// ---------------------------------------------------------------------------
package otp_pkg;

   localparam int COORD_BITS  = 32;
   localparam int RADIUS_BITS = 31;
   localparam int UNIT_BITS   = 24;            // fraction bits of unit vectors
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int MAG_BITS    = 31;            // normalized magnitudes
   localparam int AK_BITS     = 35;            // normalized |k|, holds saturation
   localparam int LEN_BITS    = 32;
   localparam int SQ_BITS     = 64;
   localparam int SQ_STEPS    = SQ_BITS / 2;
   localparam int SQ2_BITS    = 2 * UNIT_BITS + 2;
   localparam int SQ2_STEPS   = UNIT_BITS + 1;
   localparam int VEC_BITS    = UNIT_BITS + 2;
   localparam int NORM_CELLS  = 5;
   localparam int LANES       = 3;
   localparam int LANE_X      = 0;
   localparam int LANE_Y      = 1;
   localparam int LANE_K      = 2;

   localparam logic [AK_BITS-1:0] AK_LIMIT = 35'h2_0000_0000;
   localparam logic [AK_BITS-1:0] AK_SAT   = 35'h4_0000_0000;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_COINCIDENT = 2'd1,
      STATUS_NO_TANGENT = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_center_x;
      logic signed [COORD_BITS-1:0] first_center_y;
      logic signed [COORD_BITS-1:0] first_center_z;
      logic [RADIUS_BITS-1:0]       first_radius;
      logic                         first_clockwise;
      logic signed [COORD_BITS-1:0] second_center_x;
      logic signed [COORD_BITS-1:0] second_center_y;
      logic signed [COORD_BITS-1:0] second_center_z;
      logic [RADIUS_BITS-1:0]       second_radius;
      logic                         second_clockwise;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_point_x;
      logic signed [COORD_BITS-1:0] first_point_y;
      logic signed [COORD_BITS-1:0] first_point_z;
      logic signed [COORD_BITS-1:0] second_point_x;
      logic signed [COORD_BITS-1:0] second_point_y;
      logic signed [COORD_BITS-1:0] second_point_z;
      logic [1:0]                   tangent_status;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    neg_x;
      logic    neg_y;
      logic    neg_k;
      logic    same;
      logic    coincident;
      logic    no_tangent;
   } ctx_type;

   typedef struct packed {
      ctx_type              ctx;
      logic [MAG_BITS-1:0]  ax;
      logic [MAG_BITS-1:0]  ay;
      logic [AK_BITS-1:0]   ak;
   } norm_type;

   typedef struct packed {
      ctx_type                              ctx;
      logic [LEN_BITS-1:0]                  den;
      logic [LANES-1:0][LEN_BITS-1:0]       rem;
      logic [LANES-1:0][UNIT_BITS-1:0]      quo;
      logic [LANES-1:0]                     one;
   } div_type;

   typedef struct packed {
      ctx_type                     ctx;
      logic signed [VEC_BITS-1:0]  ux;
      logic signed [VEC_BITS-1:0]  uy;
      logic signed [VEC_BITS-1:0]  c;
   } unit_type;

endpackage

@@ hw/rtl/otp_norm_cell.sv @@
// ---------------------------------------------------------------------------
// otp_norm_cell
// One normalizer step: shifts the magnitudes left by SHIFT when room is left.
// ---------------------------------------------------------------------------
module otp_norm_cell import otp_pkg::*; #(
   parameter int SHIFT = 1
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  norm_type in_data,
   output logic     out_valid,
   output norm_type out_data
);

   logic [MAG_BITS-1:0]       m;
   logic                      do_shift;
   logic [AK_BITS+SHIFT-1:0]  ak_wide;
   logic                      valid_ff;
   norm_type                  data_ff;
   norm_type                  data_in;

   always_comb begin
      m        = (in_data.ax > in_data.ay) ? in_data.ax : in_data.ay;
      do_shift = (m >> (MAG_BITS - SHIFT)) == '0;
      ak_wide  = {in_data.ak, {SHIFT{1'b0}}};
      data_in  = in_data;
      if (do_shift) begin
         data_in.ax = in_data.ax << SHIFT;
         data_in.ay = in_data.ay << SHIFT;
         // |k| that would pass 2^33 is clamped to 2^34 (always above any length)
         data_in.ak = (ak_wide > {{SHIFT{1'b0}}, AK_LIMIT}) ? AK_SAT
                                                           : ak_wide[AK_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hw/rtl/otp_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// otp_sqrt_cell
// One digit of the bitwise integer square root, with a side payload.
// ---------------------------------------------------------------------------
module otp_sqrt_cell #(
   parameter int WIDTH = 64,
   parameter int STEP  = 0,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_rad,
   input  logic [WIDTH-1:0] in_root,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_rad,
   output logic [WIDTH-1:0] out_root,
   output logic [PAY_W-1:0] out_pay
);

   localparam logic [WIDTH:0] BIT = (WIDTH + 1)'(1) << (2 * STEP);

   logic [WIDTH:0]   trial;
   logic             take;
   logic [WIDTH-1:0] rad_in;
   logic [WIDTH-1:0] root_in;
   logic             valid_ff;
   logic [WIDTH-1:0] rad_ff;
   logic [WIDTH-1:0] root_ff;
   logic [PAY_W-1:0] pay_ff;

   always_comb begin
      trial   = {1'b0, in_root} + BIT;
      take    = {1'b0, in_rad} >= trial;
      rad_in  = take ? (in_rad - trial[WIDTH-1:0]) : in_rad;
      root_in = take ? ((in_root >> 1) + BIT[WIDTH-1:0]) : (in_root >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         pay_ff  <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_root  = root_ff;
   assign out_pay   = pay_ff;

endmodule

@@ hw/rtl/otp_div_cell.sv @@
// ---------------------------------------------------------------------------
// otp_div_cell
// One restoring division step for the three fraction lanes (x, y, k).
// ---------------------------------------------------------------------------
module otp_div_cell import otp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    out_valid,
   output div_type out_data
);

   logic [LEN_BITS:0] shifted [LANES];
   logic [LANES-1:0]  take;
   logic              valid_ff;
   div_type           data_ff;
   div_type           data_in;

   always_comb begin
      data_in = in_data;
      for (int l = 0; l < LANES; l++) begin
         shifted[l] = {in_data.rem[l], 1'b0};
         take[l]    = shifted[l] >= {1'b0, in_data.den};
         data_in.rem[l] = take[l] ? LEN_BITS'(shifted[l] - {1'b0, in_data.den})
                                  : shifted[l][LEN_BITS-1:0];
         data_in.quo[l] = {in_data.quo[l][UNIT_BITS-2:0], take[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hw/rtl/oriented_circle_tangent_points.sv @@
// Order: stage A, normalizer, C, D, square root, E, divider, F, sine root, H, I, J, K.
// Throughput: one item per cycle; the whole pipeline holds while an rsp beat is stalled.
// Depth is set by the 32-cell square root, the 24-cell divider and the 25-cell sine root.
// Reset: synchronous, active high; clears the valid bits of every stage, no clearing pass.
// ---------------------------------------------------------------------------
// oriented_circle_tangent_points
// Common tangent points of two oriented circles as a chain of pipelined cells.
// ---------------------------------------------------------------------------
`include "oriented_circle_tangent_points_assert.svh"

module oriented_circle_tangent_points import otp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int DIV_STEPS = UNIT_BITS;
   localparam int PROD_BITS = 2 * VEC_BITS;
   localparam int TX_BITS   = PROD_BITS + 1 - UNIT_BITS;
   localparam int RP_BITS   = RADIUS_BITS + 1 + TX_BITS;
   localparam int RV_BITS   = RP_BITS - UNIT_BITS;
   localparam int SUM_BITS  = RV_BITS + 1;
   localparam int NORM_W    = $bits(norm_type);
   localparam int UNIT_W    = $bits(unit_type);

   localparam logic [UNIT_BITS:0]      ONE_MAG   = (UNIT_BITS + 1)'(1) << UNIT_BITS;
   localparam logic [SQ2_BITS-1:0]     ONE_SQ    = SQ2_BITS'(1) << (2 * UNIT_BITS);
   localparam logic [PROD_BITS:0]      HALF_T    = (PROD_BITS + 1)'(1) << (UNIT_BITS - 1);
   localparam logic [RP_BITS-1:0]      HALF_R    = RP_BITS'(1) << (UNIT_BITS - 1);
   localparam logic signed [SUM_BITS-1:0] SAT_HI =
      SUM_BITS'((64'(1) << (COORD_BITS - 1)) - 64'(1));
   localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // ---------------- stage A: differences and magnitudes ----------------
   logic signed [DIFF_BITS-1:0] dx_c, dy_c, k_c;
   logic [DIFF_BITS-1:0]        r1_c, r2_c;
   ctx_type                     ctx_c;
   logic                        a_valid_ff;
   ctx_type                     a_ctx_ff;
   logic [DIFF_BITS-1:0]        a_ax_ff, a_ay_ff, a_ak_ff;

   always_comb begin
      dx_c = {req_data.second_center_x[COORD_BITS-1], req_data.second_center_x}
           - {req_data.first_center_x[COORD_BITS-1], req_data.first_center_x};
      dy_c = {req_data.second_center_y[COORD_BITS-1], req_data.second_center_y}
           - {req_data.first_center_y[COORD_BITS-1], req_data.first_center_y};
      r1_c = {2'b00, req_data.first_radius};
      r2_c = {2'b00, req_data.second_radius};
      ctx_c.req        = req_data;
      ctx_c.same       = req_data.first_clockwise == req_data.second_clockwise;
      k_c              = ctx_c.same ? $signed(r1_c - r2_c) : $signed(r1_c + r2_c);
      ctx_c.neg_x      = dx_c[DIFF_BITS-1];
      ctx_c.neg_y      = dy_c[DIFF_BITS-1];
      ctx_c.neg_k      = k_c[DIFF_BITS-1];
      ctx_c.coincident = (dx_c == '0) && (dy_c == '0);
      ctx_c.no_tangent = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ctx_ff <= ctx_c;
         a_ax_ff  <= dx_c[DIFF_BITS-1] ? DIFF_BITS'(-dx_c) : dx_c;
         a_ay_ff  <= dy_c[DIFF_BITS-1] ? DIFF_BITS'(-dy_c) : dy_c;
         a_ak_ff  <= k_c[DIFF_BITS-1] ? DIFF_BITS'(-k_c) : k_c;
      end
   end

   // ---------------- right pre-shift, then the normalizer chain ----------------
   logic [DIFF_BITS-1:0]  m_a;
   logic [DIFF_BITS-1:0]  ax_r, ay_r, ak_r;
   norm_type              norm_data [NORM_CELLS+1];
   logic [NORM_CELLS:0]   norm_valid;

   always_comb begin
      m_a = (a_ax_ff > a_ay_ff) ? a_ax_ff : a_ay_ff;
      priority if (m_a[DIFF_BITS-1]) begin
         ax_r = a_ax_ff >> 2;
         ay_r = a_ay_ff >> 2;
         ak_r = a_ak_ff >> 2;
      end else if (m_a[DIFF_BITS-2]) begin
         ax_r = a_ax_ff >> 1;
         ay_r = a_ay_ff >> 1;
         ak_r = a_ak_ff >> 1;
      end else begin
         ax_r = a_ax_ff;
         ay_r = a_ay_ff;
         ak_r = a_ak_ff;
      end
      norm_data[0].ctx = a_ctx_ff;
      norm_data[0].ax  = ax_r[MAG_BITS-1:0];
      norm_data[0].ay  = ay_r[MAG_BITS-1:0];
      norm_data[0].ak  = AK_BITS'(ak_r);
   end
   assign norm_valid[0] = a_valid_ff;

   for (genvar i = 0; i < NORM_CELLS; i++) begin : gen_norm
      otp_norm_cell #(
         .SHIFT ((1 << (NORM_CELLS - 1)) >> i)
      ) u_norm (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (norm_valid[i]),
         .in_data   (norm_data[i]),
         .out_valid (norm_valid[i+1]),
         .out_data  (norm_data[i+1])
      );
   end

   // ---------------- stage C: squares, stage D: sum ----------------
   logic                      c_valid_ff, d_valid_ff;
   norm_type                  c_data_ff, d_data_ff;
   logic [2*MAG_BITS-1:0]     c_sqx_ff, c_sqy_ff;
   logic [SQ_BITS-1:0]        d_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= norm_valid[NORM_CELLS];
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_data_ff <= norm_data[NORM_CELLS];
         c_sqx_ff  <= norm_data[NORM_CELLS].ax * norm_data[NORM_CELLS].ax;
         c_sqy_ff  <= norm_data[NORM_CELLS].ay * norm_data[NORM_CELLS].ay;
         d_data_ff <= c_data_ff;
         d_rad_ff  <= SQ_BITS'(c_sqx_ff) + SQ_BITS'(c_sqy_ff);
      end
   end

   // ---------------- centre distance root ----------------
   logic [SQ_BITS-1:0] s1_rad  [SQ_STEPS+1];
   logic [SQ_BITS-1:0] s1_root [SQ_STEPS+1];
   logic [NORM_W-1:0]  s1_pay  [SQ_STEPS+1];
   logic [SQ_STEPS:0]  s1_valid;

   assign s1_rad[0]   = d_rad_ff;
   assign s1_root[0]  = '0;
   assign s1_pay[0]   = d_data_ff;
   assign s1_valid[0] = d_valid_ff;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : gen_sq1
      otp_sqrt_cell #(
         .WIDTH (SQ_BITS),
         .STEP  (SQ_STEPS - 1 - i),
         .PAY_W (NORM_W)
      ) u_sqrt (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (s1_valid[i]),
         .in_rad    (s1_rad[i]),
         .in_root   (s1_root[i]),
         .in_pay    (s1_pay[i]),
         .out_valid (s1_valid[i+1]),
         .out_rad   (s1_rad[i+1]),
         .out_root  (s1_root[i+1]),
         .out_pay   (s1_pay[i+1])
      );
   end

   // ---------------- stage E: divider setup ----------------
   norm_type                        s1_out;
   logic [LEN_BITS-1:0]             len_c;
   logic                            no_tan_c;
   logic [LANES-1:0][LEN_BITS-1:0]  num_c;
   div_type                         e_in;
   logic                            e_valid_ff;
   div_type                         e_data_ff;

   always_comb begin
      s1_out   = norm_type'(s1_pay[SQ_STEPS]);
      len_c    = s1_root[SQ_STEPS][LEN_BITS-1:0];
      no_tan_c = s1_out.ak > AK_BITS'(len_c);
      num_c[LANE_X] = LEN_BITS'(s1_out.ax);
      num_c[LANE_Y] = LEN_BITS'(s1_out.ay);
      num_c[LANE_K] = no_tan_c ? '0 : s1_out.ak[LEN_BITS-1:0];
      e_in.ctx            = s1_out.ctx;
      e_in.ctx.no_tangent = no_tan_c;
      e_in.den            = len_c;
      for (int l = 0; l < LANES; l++) begin
         e_in.one[l] = num_c[l] >= len_c;
         e_in.rem[l] = e_in.one[l] ? '0 : num_c[l];
         e_in.quo[l] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= s1_valid[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_data_ff <= e_in;
      end
   end

   // ---------------- fraction divider chain ----------------
   div_type              div_data [DIV_STEPS+1];
   logic [DIV_STEPS:0]   div_valid;

   assign div_data[0]  = e_data_ff;
   assign div_valid[0] = e_valid_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : gen_div
      otp_div_cell u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[i]),
         .in_data   (div_data[i]),
         .out_valid (div_valid[i+1]),
         .out_data  (div_data[i+1])
      );
   end

   // ---------------- stage F: signed unit values, cos squared ----------------
   div_type                      div_out;
   logic [UNIT_BITS:0]           mag_c [LANES];
   logic signed [VEC_BITS-1:0]   vec_c [LANES];
   unit_type                     f_in;
   logic                         f_valid_ff;
   unit_type                     f_data_ff;
   logic [SQ2_BITS-1:0]          f_cc_ff;

   always_comb begin
      div_out = div_data[DIV_STEPS];
      for (int l = 0; l < LANES; l++) begin
         mag_c[l] = div_out.one[l] ? ONE_MAG : {1'b0, div_out.quo[l]};
         vec_c[l] = {1'b0, mag_c[l]};
      end
      f_in.ctx = div_out.ctx;
      f_in.ux  = div_out.ctx.neg_x ? -vec_c[LANE_X] : vec_c[LANE_X];
      f_in.uy  = div_out.ctx.neg_y ? -vec_c[LANE_Y] : vec_c[LANE_Y];
      f_in.c   = div_out.ctx.neg_k ? -vec_c[LANE_K] : vec_c[LANE_K];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_data_ff <= f_in;
         f_cc_ff   <= mag_c[LANE_K] * mag_c[LANE_K];
      end
   end

   // ---------------- sine root ----------------
   logic [SQ2_BITS-1:0] s2_rad  [SQ2_STEPS+1];
   logic [SQ2_BITS-1:0] s2_root [SQ2_STEPS+1];
   logic [UNIT_W-1:0]   s2_pay  [SQ2_STEPS+1];
   logic [SQ2_STEPS:0]  s2_valid;

   assign s2_rad[0]   = ONE_SQ - f_cc_ff;
   assign s2_root[0]  = '0;
   assign s2_pay[0]   = f_data_ff;
   assign s2_valid[0] = f_valid_ff;

   for (genvar i = 0; i < SQ2_STEPS; i++) begin : gen_sq2
      otp_sqrt_cell #(
         .WIDTH (SQ2_BITS),
         .STEP  (SQ2_STEPS - 1 - i),
         .PAY_W (UNIT_W)
      ) u_sqrt (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (s2_valid[i]),
         .in_rad    (s2_rad[i]),
         .in_root   (s2_root[i]),
         .in_pay    (s2_pay[i]),
         .out_valid (s2_valid[i+1]),
         .out_rad   (s2_rad[i+1]),
         .out_root  (s2_root[i+1]),
         .out_pay   (s2_pay[i+1])
      );
   end

   // ---------------- stage H: rotation products ----------------
   // product slots per point: x*cos, y*sin, y*cos, x*sin
   unit_type                     s2_out;
   logic signed [VEC_BITS-1:0]   s_c, sn1_c, sn2_c, cs2_c, px2_c, py2_c;
   logic                         h_valid_ff;
   ctx_type                      h_ctx_ff;
   logic signed [PROD_BITS-1:0]  h_prod_ff [8];

   always_comb begin
      s2_out = unit_type'(s2_pay[SQ2_STEPS]);
      s_c    = {1'b0, s2_root[SQ2_STEPS][UNIT_BITS:0]};
      sn1_c  = s2_out.ctx.req.first_clockwise ? s_c : -s_c;
      sn2_c  = s2_out.ctx.req.second_clockwise ? -s_c : s_c;
      cs2_c  = s2_out.ctx.same ? -s2_out.c : s2_out.c;
      px2_c  = -s2_out.ux;
      py2_c  = -s2_out.uy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (en) begin
         h_valid_ff <= s2_valid[SQ2_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ctx_ff     <= s2_out.ctx;
         h_prod_ff[0] <= s2_out.ux * s2_out.c;
         h_prod_ff[1] <= s2_out.uy * sn1_c;
         h_prod_ff[2] <= s2_out.uy * s2_out.c;
         h_prod_ff[3] <= s2_out.ux * sn1_c;
         h_prod_ff[4] <= px2_c * cs2_c;
         h_prod_ff[5] <= py2_c * sn2_c;
         h_prod_ff[6] <= py2_c * cs2_c;
         h_prod_ff[7] <= px2_c * sn2_c;
      end
   end

   // ---------------- stage I: turned unit vectors ----------------
   // order: first x, first y, second x, second y
   logic signed [PROD_BITS:0]   t_sum_c [4];
   logic                        i_valid_ff;
   ctx_type                     i_ctx_ff;
   logic signed [TX_BITS-1:0]   i_t_ff [4];

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         t_sum_c[2*p]   = (PROD_BITS + 1)'(h_prod_ff[4*p])
                        - (PROD_BITS + 1)'(h_prod_ff[4*p+1]) + $signed(HALF_T);
         t_sum_c[2*p+1] = (PROD_BITS + 1)'(h_prod_ff[4*p+2])
                        + (PROD_BITS + 1)'(h_prod_ff[4*p+3]) + $signed(HALF_T);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else if (en) begin
         i_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         i_ctx_ff <= h_ctx_ff;
         for (int n = 0; n < 4; n++) begin
            i_t_ff[n] <= t_sum_c[n][UNIT_BITS +: TX_BITS];
         end
      end
   end

   // ---------------- stage J: radius scaling ----------------
   logic signed [RADIUS_BITS:0] r_c [2];
   logic                        j_valid_ff;
   ctx_type                     j_ctx_ff;
   logic signed [RP_BITS-1:0]   j_rp_ff [4];

   assign r_c[0] = {1'b0, i_ctx_ff.req.first_radius};
   assign r_c[1] = {1'b0, i_ctx_ff.req.second_radius};

   always_ff @(posedge clock) begin
      if (reset) begin
         j_valid_ff <= 1'b0;
      end else if (en) begin
         j_valid_ff <= i_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         j_ctx_ff <= i_ctx_ff;
         for (int n = 0; n < 4; n++) begin
            j_rp_ff[n] <= r_c[n/2] * i_t_ff[n];
         end
      end
   end

   // ---------------- stage K: round, offset, saturate, output register ----------------
   logic [RP_BITS-1:0]            rp_rnd_c [4];
   logic signed [SUM_BITS-1:0]    pos_c    [4];
   logic signed [COORD_BITS-1:0]  sat_c    [4];
   logic signed [COORD_BITS-1:0]  cen_c    [4];
   status_type                    status_c;
   rsp_type                       rsp_in;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;

   always_comb begin
      cen_c[0] = j_ctx_ff.req.first_center_x;
      cen_c[1] = j_ctx_ff.req.first_center_y;
      cen_c[2] = j_ctx_ff.req.second_center_x;
      cen_c[3] = j_ctx_ff.req.second_center_y;
      for (int n = 0; n < 4; n++) begin
         rp_rnd_c[n] = j_rp_ff[n] + HALF_R;
         pos_c[n]    = $signed({rp_rnd_c[n][RP_BITS-1], rp_rnd_c[n][RP_BITS-1:UNIT_BITS]})
                     + SUM_BITS'(cen_c[n]);
         priority if (pos_c[n] > SAT_HI) begin
            sat_c[n] = SAT_HI[COORD_BITS-1:0];
         end else if (pos_c[n] < SAT_LO) begin
            sat_c[n] = SAT_LO[COORD_BITS-1:0];
         end else begin
            sat_c[n] = pos_c[n][COORD_BITS-1:0];
         end
      end
      priority if (j_ctx_ff.coincident) begin
         status_c = STATUS_COINCIDENT;
      end else if (j_ctx_ff.no_tangent) begin
         status_c = STATUS_NO_TANGENT;
      end else begin
         status_c = STATUS_OK;
      end
      rsp_in = '0;
      rsp_in.tangent_status = status_c;
      if (status_c == STATUS_OK) begin
         rsp_in.first_point_x  = sat_c[0];
         rsp_in.first_point_y  = sat_c[1];
         rsp_in.first_point_z  = j_ctx_ff.req.first_center_z;
         rsp_in.second_point_x = sat_c[2];
         rsp_in.second_point_y = sat_c[3];
         rsp_in.second_point_z = j_ctx_ff.req.second_center_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= j_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   `OTP_ASSERT_IMPLIES(a_fail_zeroes_points,
      rsp_valid && rsp_data.tangent_status != STATUS_OK,
      rsp_data.first_point_x == '0 && rsp_data.first_point_y == '0 && rsp_data.first_point_z == '0 && rsp_data.second_point_x == '0 && rsp_data.second_point_y == '0 && rsp_data.second_point_z == '0,
      "failed status beat carries nonzero points")
   `OTP_ASSERT_IMPLIES(a_norm_in_range,
      norm_valid[NORM_CELLS] && !norm_data[NORM_CELLS].ctx.coincident,
      norm_data[NORM_CELLS].ax[MAG_BITS-1] || norm_data[NORM_CELLS].ay[MAG_BITS-1],
      "normalized magnitude below 2^30")
   `OTP_ASSERT_NEXT(a_drain,
      rsp_valid && !rsp_stall && !j_valid_ff,
      !rsp_valid,
      "rsp beat repeated after it was taken")

endmodule

@@ bench/oriented_circle_tangent_points_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// oriented_circle_tangent_points_tb
// Drives pairs of oriented circles into the tangent point pipeline with
// random gaps and rsp stalls, predicts each tangent pair in fixed point and
// compares every rsp beat against the oldest prediction, listing fields on a mismatch.
// ---------------------------------------------------------------------------
module oriented_circle_tangent_points_tb import otp_pkg::*; ();

   localparam int LATENCY     = 95;
   localparam int WATCH_LIMIT = 20000;
   localparam longint ONE_U   = 64'sd1 << UNIT_BITS;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type tangent_queue[$];
   int      error_count;
   int      idle_cycles;
   int      stall_hold;
   bit      stall_enable;

   oriented_circle_tangent_points dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unit_ratio(longint unsigned num, longint unsigned den);
      longint unsigned q, rem;
      q = 0;
      rem = num;
      if (rem >= den) return ONE_U;
      for (int i = 0; i < UNIT_BITS; i++) begin
         rem <<= 1;
         q <<= 1;
         if (rem >= den) begin
            rem -= den;
            q |= 1;
         end
      end
      return longint'(q);
   endfunction

   function automatic longint round_unit(longint v);
      longint w;
      w = v + (ONE_U >>> 1);
      if (w >= 0) return w >>> UNIT_BITS;
      return -longint'((unsigned'(-w) + unsigned'(ONE_U) - 1) >> UNIT_BITS);
   endfunction

   function automatic longint clamp_coord(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   // center + r * rotate((px,py), (cs,sn)); returns {x, y}
   function automatic logic [63:0] touch_point(longint cx, longint cy, longint r,
                                                longint px, longint py,
                                                longint cs, longint sn);
      longint tx, ty, ox, oy;
      tx = round_unit(px * cs - py * sn);
      ty = round_unit(py * cs + px * sn);
      ox = clamp_coord(cx + round_unit(r * tx));
      oy = clamp_coord(cy + round_unit(r * ty));
      return {ox[31:0], oy[31:0]};
   endfunction

   function automatic rsp_type predict_tangent(req_type q);
      rsp_type         e;
      longint          x1, y1, x2, y2, r1, r2, dx, dy, k, ux, uy, c, s;
      longint unsigned ax, ay, ak, m, len;
      int              sh;
      bit              same;
      logic [63:0]     p;
      e = '0;
      x1 = q.first_center_x;  y1 = q.first_center_y;
      x2 = q.second_center_x; y2 = q.second_center_y;
      r1 = longint'(q.first_radius);
      r2 = longint'(q.second_radius);
      same = q.first_clockwise == q.second_clockwise;
      dx = x2 - x1;
      dy = y2 - y1;
      k = same ? r1 - r2 : r1 + r2;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      ak = k < 0 ? -k : k;
      sh = 0;
      if (ax == 0 && ay == 0) begin
         e.tangent_status = STATUS_COINCIDENT;
         return e;
      end
      m = ax > ay ? ax : ay;
      if (m >= (64'd1 << 31)) begin
         while ((m >> sh) >= (64'd1 << 31)) sh++;
         ax >>= sh; ay >>= sh; ak >>= sh;
      end else begin
         while ((m << sh) < (64'd1 << 30)) sh++;
         ax <<= sh; ay <<= sh;
         if (ak > ((64'd1 << 33) >> sh)) ak = 64'd1 << 34;
         else ak <<= sh;
      end
      len = int_sqrt(ax * ax + ay * ay);
      if (ak > len) begin
         e.tangent_status = STATUS_NO_TANGENT;
         return e;
      end
      ux = unit_ratio(ax, len);
      uy = unit_ratio(ay, len);
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
      c = unit_ratio(ak, len);
      s = longint'(int_sqrt(unsigned'(ONE_U * ONE_U - c * c)));
      if (k < 0) c = -c;
      p = touch_point(x1, y1, r1, ux, uy, c, q.first_clockwise ? s : -s);
      e.first_point_x = p[63:32];
      e.first_point_y = p[31:0];
      p = touch_point(x2, y2, r2, -ux, -uy, same ? -c : c,
                      q.second_clockwise ? -s : s);
      e.second_point_x = p[63:32];
      e.second_point_y = p[31:0];
      e.first_point_z  = q.first_center_z;
      e.second_point_z = q.second_center_z;
      e.tangent_status = STATUS_OK;
      return e;
   endfunction

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one req beat; gap cycles idle first, then wait for acceptance
   task automatic send_circles(req_type q, bit idle_ok);
      int gap;
      gap = idle_ok ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= req_type'({8{$urandom}});
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tangent_queue.push_back(predict_tangent(q));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (tangent_queue.size() != 0) @(posedge clock);
   endtask

   function automatic req_type circle_pair(longint x1, longint y1, longint r1, bit cw1,
                                           longint x2, longint y2, longint r2, bit cw2);
      req_type q;
      q = '0;
      q.first_center_x = 32'(x1);  q.first_center_y = 32'(y1);
      q.first_radius = 31'(r1);    q.first_clockwise = cw1;
      q.second_center_x = 32'(x2); q.second_center_y = 32'(y2);
      q.second_radius = 31'(r2);   q.second_clockwise = cw2;
      q.first_center_z = $urandom;
      q.second_center_z = $urandom;
      return q;
   endfunction

   task automatic test_directed();
      req_type q;
      stall_enable = 1'b0;
      // all four direction combinations, axis-aligned and diagonal
      for (int d = 0; d < 4; d++) begin
         send_circles(circle_pair(0, 0, 32'h1_0000, d[0], 32'h10_0000, 0, 32'h2_0000, d[1]), 0);
         send_circles(circle_pair(32'h5_0000, -32'sh3_0000, 32'h8000, d[0],
                                  -32'sh7_0000, 32'h9_0000, 32'h1_8000, d[1]), 1);
      end
      // coincident centers
      send_circles(circle_pair(32'h1234, -32'sh77, 5, 0, 32'h1234, -32'sh77, 9, 1), 0);
      // no tangent: radii too large for the spacing
      send_circles(circle_pair(0, 0, 32'h10_0000, 0, 32'h1_0000, 0, 32'h10_0000, 1), 0);
      send_circles(circle_pair(0, 0, 32'h40_0000, 0, 32'h1_0000, 0, 0, 0), 0);
      // exact touch: k equals distance
      send_circles(circle_pair(0, 0, 32'h3_0000, 1, 32'h5_0000, 0, 32'h2_0000, 0), 0);
      send_circles(circle_pair(0, 0, 32'h3_0000, 1, 0, 32'h1_0000, 32'h2_0000, 1), 0);
      // zero radii, extreme coordinates, maximal radii
      send_circles(circle_pair(-64'sh8000_0000, -64'sh8000_0000, 0, 0,
                               32'h7fff_ffff, 32'h7fff_ffff, 0, 1), 0);
      send_circles(circle_pair(32'h7fff_ffff, -64'sh8000_0000, 31'h7fff_ffff, 1,
                               -64'sh8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 1), 0);
      send_circles(circle_pair(32'h7fff_fff0, 0, 31'h7fff_ffff, 0,
                               32'h7fff_ffff, 1, 31'h7fff_fff0, 0), 0);
      send_circles(circle_pair(0, 0, 1, 0, 1, 0, 0, 1), 0);
      send_circles(circle_pair(0, 0, 0, 1, 0, -1, 0, 1), 0);
      // huge distance with near-maximal radii, saturating results
      send_circles(circle_pair(-64'sh8000_0000, 0, 31'h7fff_ffff, 0,
                               32'h7fff_ffff, 0, 31'h7fff_0000, 0), 0);
      q = '1;
      send_circles(q, 0);
      q = '0;
      send_circles(q, 0);
      drain_results();
   endtask

   function automatic longint rand_coord(int span_bits);
      longint v;
      v = longint'($urandom) & ((64'd1 << span_bits) - 1);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   task automatic test_random(int count);
      req_type q;
      int      span, mode;
      longint  spacing;
      stall_enable = 1'b1;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 9);
         span = $urandom_range(2, 31);
         if (mode < 2) begin
            // raw noise over every bit
            q = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
         end else begin
            q = circle_pair(rand_coord(span), rand_coord(span), 0, $urandom_range(0, 1),
                            rand_coord(span), rand_coord(span), 0, $urandom_range(0, 1));
            spacing = q.second_center_x - q.first_center_x;
            if (spacing < 0) spacing = -spacing;
            spacing = spacing >> 2;
            if (spacing > 31'h7fff_ffff) spacing = 31'h7fff_ffff;
            // radii mostly below a quarter of the spacing so tangents exist
            q.first_radius  = (mode < 8) ? 31'($urandom_range(0, 32'(spacing)))
                                         : 31'($urandom);
            q.second_radius = (mode < 8) ? 31'($urandom_range(0, 32'(spacing)))
                                         : 31'($urandom);
            if (mode == 9) begin
               q.second_center_x = q.first_center_x;
               q.second_center_y = q.first_center_y;
            end
         end
         send_circles(q, 1);
         if (n == count / 2) drain_results();  // sender holds until all rsp beats are in
      end
      drain_results();
   endtask

   // rsp stall pattern: mostly short runs, now and then a long hold
   always @(posedge clock) begin
      if (reset || !stall_enable) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         rsp_stall  <= 1'b1;
         stall_hold <= stall_hold - 1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(8, 40);
      end else begin
         rsp_stall  <= ($urandom_range(0, 99) < 25);
      end
   end

   // rsp checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tangent_queue.size() == 0) begin
            $display("%0t: rsp beat with no prediction waiting: %h", $time, rsp_data);
            error_count++;
         end else begin
            want = tangent_queue.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
               $display("   p1 %h %h %h  p2 %h %h %h  st %0d (expected)",
                        want.first_point_x, want.first_point_y, want.first_point_z,
                        want.second_point_x, want.second_point_y, want.second_point_z,
                        want.tangent_status);
               $display("   p1 %h %h %h  p2 %h %h %h  st %0d (actual)",
                        rsp_data.first_point_x, rsp_data.first_point_y,
                        rsp_data.first_point_z, rsp_data.second_point_x,
                        rsp_data.second_point_y, rsp_data.second_point_z,
                        rsp_data.tangent_status);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCH_LIMIT) begin
            $display("[oriented_circle_tangent_points] ERROR");
            $finish;
         end
      end
   end

   initial begin
      error_count  = 0;
      idle_cycles  = 0;
      stall_enable = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1850);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && tangent_queue.size() == 0) begin
         $display("[oriented_circle_tangent_points] OK");
      end else begin
         $display("[oriented_circle_tangent_points] ERROR");
      end
      $finish;
   end
endmodule
